[design/nfci_pkg.sv]
// Shared types and constants of the NOR flash command interface.
// Used by nfci_cmd, nfci_array and the top level; depends on nothing.
`default_nettype none

package nfci_pkg;

	// word address width of the flash array
	localparam int ADDR_WIDTH = 16;
	localparam int WORD_WIDTH = 16;

	typedef logic [ADDR_WIDTH-1:0] aidx_t;
	typedef logic [WORD_WIDTH-1:0] word_t;

	// read mode codes as seen on the result
	typedef enum logic [1:0] {
		RM_ARRAY = 2'd0,
		RM_ID    = 2'd1,
		RM_CFI   = 2'd2
	} rmode_t;

	// unlock addresses and command bytes
	localparam logic [15:0] UNLOCK_A       = 16'h5555;
	localparam logic [15:0] UNLOCK_B       = 16'h2AAA;
	localparam logic [7:0]  CMD_UNLOCK1    = 8'hAA;
	localparam logic [7:0]  CMD_UNLOCK2    = 8'h55;
	localparam logic [7:0]  CMD_ID_ENTRY   = 8'h90;
	localparam logic [7:0]  CMD_CFI_ENTRY  = 8'h98;
	localparam logic [7:0]  CMD_RESET      = 8'hF0;
	localparam logic [7:0]  CMD_PROGRAM    = 8'hA0;
	localparam logic [7:0]  CMD_ERASE      = 8'h80;
	localparam logic [7:0]  CMD_ERASE_CHIP = 8'h10;

	// register reset values
	localparam logic [7:0]  MFR_CODE_RST  = 8'hBF;
	localparam logic [15:0] DEV_CODE_RST  = 16'h234B;
	localparam logic [4:0]  SIZE_CODE_RST = 5'd21;

	// register indexes on the configuration port
	localparam logic [1:0] REG_MFR_CODE  = 2'd0;
	localparam logic [1:0] REG_DEV_CODE  = 2'd1;
	localparam logic [1:0] REG_SIZE_CODE = 2'd2;

	// ID and CFI query addresses
	localparam logic [15:0] ID_ADDR_MFR   = 16'h0000;
	localparam logic [15:0] ID_ADDR_DEV   = 16'h0001;
	localparam logic [15:0] CFI_ADDR_Q    = 16'h0010;
	localparam logic [15:0] CFI_ADDR_R    = 16'h0011;
	localparam logic [15:0] CFI_ADDR_Y    = 16'h0012;
	localparam logic [15:0] CFI_ADDR_CS0  = 16'h0013;
	localparam logic [15:0] CFI_ADDR_CS1  = 16'h0014;
	localparam logic [15:0] CFI_ADDR_SIZE = 16'h0027;

	localparam word_t CFI_Q   = 16'h0051;
	localparam word_t CFI_R   = 16'h0052;
	localparam word_t CFI_Y   = 16'h0059;
	localparam word_t CFI_CS0 = 16'h0001;
	localparam word_t CFI_CS1 = 16'h0007;

	localparam word_t ERASED_WORD = {WORD_WIDTH{1'b1}};

	// decoded action of one bus access
	typedef struct packed {
		logic   prog;
		logic   erase;
		rmode_t read_mode;
	} cmd_ctrl_t;

	// access request to the array store
	typedef struct packed {
		logic  rd_en;
		aidx_t rd_addr;
		logic  wr_en;
		aidx_t wr_addr;
		word_t wr_data;
		logic  clear_start;
	} mem_req_t;

endpackage

`default_nettype wire

[design/nfci_cmd.sv]
// Command sequencer: unlock / command decoding and the read mode register.
// Depends on nfci_pkg.
`default_nettype none

module nfci_cmd (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               commit,
	input  wire               is_write,
	input  wire [15:0]        address,
	input  wire [15:0]        wdata,
	output nfci_pkg::cmd_ctrl_t ctrl
);
	import nfci_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_UNLOCK1 = 7'b0000010,
		ST_UNLOCK2 = 7'b0000100,
		ST_PROGRAM = 7'b0001000,
		ST_ERASE1  = 7'b0010000,
		ST_ERASE2  = 7'b0100000,
		ST_ERASE3  = 7'b1000000
	} step_t;

	step_t  step_q, step_d, step_w;
	rmode_t mode_q, mode_d, mode_w;
	logic   program_w, erase_w;
	logic   hit_a, hit_b;
	logic [7:0] cmd;

	assign cmd   = wdata[7:0];
	assign hit_a = (address == UNLOCK_A);
	assign hit_b = (address == UNLOCK_B);

	// next step for a write; anything off-sequence falls back to idle
	always_comb begin
		step_w    = ST_IDLE;
		mode_w    = mode_q;
		program_w = 1'b0;
		erase_w   = 1'b0;
		case (step_q)
			ST_IDLE: begin
				if (hit_a && cmd == CMD_UNLOCK1) step_w = ST_UNLOCK1;
			end
			ST_UNLOCK1: begin
				if (hit_b && cmd == CMD_UNLOCK2) step_w = ST_UNLOCK2;
			end
			ST_UNLOCK2: begin
				if (hit_a) begin
					case (cmd)
						CMD_ID_ENTRY:  mode_w = RM_ID;
						CMD_CFI_ENTRY: mode_w = RM_CFI;
						CMD_RESET:     mode_w = RM_ARRAY;
						CMD_PROGRAM:   step_w = ST_PROGRAM;
						CMD_ERASE:     step_w = ST_ERASE1;
						default:       step_w = ST_IDLE;
					endcase
				end
			end
			ST_PROGRAM: begin
				program_w = 1'b1;
			end
			ST_ERASE1: begin
				if (hit_a && cmd == CMD_UNLOCK1) step_w = ST_ERASE2;
			end
			ST_ERASE2: begin
				if (hit_b && cmd == CMD_UNLOCK2) step_w = ST_ERASE3;
			end
			ST_ERASE3: begin
				if (hit_a && cmd == CMD_ERASE_CHIP) erase_w = 1'b1;
			end
			default: step_w = ST_IDLE;
		endcase
	end

	// reads leave the sequence untouched
	always_comb begin
		step_d = is_write ? step_w : step_q;
		mode_d = is_write ? mode_w : mode_q;
		ctrl.prog      = is_write && program_w;
		ctrl.erase     = is_write && erase_w;
		ctrl.read_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			mode_q <= RM_ARRAY;
		end else if (commit) begin
			step_q <= step_d;
			mode_q <= mode_d;
		end
	end

endmodule

`default_nettype wire

[design/nfci_array.sv]
// Flash array store: one synchronous memory with registered read data
// and a sweep that fills it with the erased value. Depends on nfci_pkg.
`default_nettype none

module nfci_array (
	input  wire                clk,
	input  wire                arst_n,
	input  nfci_pkg::mem_req_t req,
	output nfci_pkg::word_t    rdata,
	output logic               busy
);
	import nfci_pkg::*;

	localparam int DEPTH = 2 ** ADDR_WIDTH;

	word_t mem [0:DEPTH-1];
	word_t rdata_q;
	logic  clr_busy_q;
	aidx_t clr_cnt_q;

	logic  we;
	aidx_t wa;
	word_t wd;

	// clear sweep owns the write port while it runs
	always_comb begin
		we = clr_busy_q || req.wr_en;
		wa = clr_busy_q ? clr_cnt_q : req.wr_addr;
		wd = clr_busy_q ? ERASED_WORD : req.wr_data;
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (req.rd_en) rdata_q <= mem[req.rd_addr];
	end

	// sweep counter, started by reset and by chip erase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (req.clear_start) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) clr_busy_q <= 1'b0;
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

`default_nettype wire

[design/nor_flash_command_interface_unit.sv]
// Command interface of an x16 parallel NOR flash. Each input word is one bus
// access (tuser 0 read, 1 write); each produces exactly one result word with
// the read data (zero for writes) and the read mode after the access. The
// array is read on accept; decode, modify and write back follow in the
// execute state, as the array read is registered; that state is held while
// the result register is full. After reset and every chip erase the array is
// swept to FFFF, one word per cycle over all 2**ADDR_WIDTH words (65536 by
// default); meanwhile no access is taken, but configuration writes still are.
`default_nettype none

module nor_flash_command_interface_unit (
	input  wire         clk,
	input  wire         arst_n,
	// access words
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [15:0] address, [31:16] write_data
	input  wire  [0:0]  s_tuser,   // [0] mode
	// result words
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [15:0] read_data
	output logic [1:0]  m_tuser,   // [1:0] read_mode
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nfci_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t    state_q;
	logic      accept, commit, out_free, clr_busy;
	logic      mode_s1;
	logic [15:0] addr_s1, data_s1;
	word_t     mem_rdata, rd_word;
	mem_req_t  mem_req;
	cmd_ctrl_t ctrl;
	logic [7:0]  mfr_code_q;
	logic [15:0] dev_code_q;
	logic [4:0]  size_code_q;
	logic        m_tvalid_q;
	logic [15:0] m_data_q;
	logic [1:0]  m_user_q;
	logic        cfg_wr;

	// handshake and sequencing
	assign s_tready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// access word held for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= s_tuser[0];
			addr_s1 <= s_tdata[15:0];
			data_s1 <= s_tdata[31:16];
		end
	end

	nfci_cmd u_cmd (
		.clk      (clk),
		.arst_n   (arst_n),
		.commit   (commit),
		.is_write (mode_s1),
		.address  (addr_s1),
		.wdata    (data_s1),
		.ctrl     (ctrl)
	);

	// array access: read on accept, program write-back on commit
	always_comb begin
		mem_req.rd_en       = accept;
		mem_req.rd_addr     = ADDR_WIDTH'(s_tdata[15:0]);
		mem_req.wr_en       = commit && ctrl.prog;
		mem_req.wr_addr     = ADDR_WIDTH'(addr_s1);
		mem_req.wr_data     = mem_rdata & data_s1;
		mem_req.clear_start = commit && ctrl.erase;
	end

	nfci_array u_array (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata),
		.busy   (clr_busy)
	);

	// read data by mode
	always_comb begin
		rd_word = '0;
		case (ctrl.read_mode)
			RM_ARRAY: rd_word = mem_rdata;
			RM_ID: begin
				if (addr_s1 == ID_ADDR_MFR)      rd_word = {8'h00, mfr_code_q};
				else if (addr_s1 == ID_ADDR_DEV) rd_word = dev_code_q;
			end
			RM_CFI: begin
				case (addr_s1)
					CFI_ADDR_Q:    rd_word = CFI_Q;
					CFI_ADDR_R:    rd_word = CFI_R;
					CFI_ADDR_Y:    rd_word = CFI_Y;
					CFI_ADDR_CS0:  rd_word = CFI_CS0;
					CFI_ADDR_CS1:  rd_word = CFI_CS1;
					CFI_ADDR_SIZE: rd_word = {11'd0, size_code_q};
					default:       rd_word = '0;
				endcase
			end
			default: rd_word = '0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_data_q <= mode_s1 ? 16'h0000 : rd_word;
			m_user_q <= ctrl.read_mode;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfr_code_q  <= MFR_CODE_RST;
			dev_code_q  <= DEV_CODE_RST;
			size_code_q <= SIZE_CODE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MFR_CODE:  mfr_code_q  <= pwdata[7:0];
				REG_DEV_CODE:  dev_code_q  <= pwdata[15:0];
				REG_SIZE_CODE: size_code_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MFR_CODE:  prdata = {24'd0, mfr_code_q};
			REG_DEV_CODE:  prdata = {16'd0, dev_code_q};
			REG_SIZE_CODE: prdata = {27'd0, size_code_q};
			default:       prdata = '0;
		endcase
	end

	// no access is taken while the array sweep runs
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("access accepted during array clear");

	// an accepted word always puts the unit in the execute state in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted word not executed");

	// a result appears only after an execute cycle
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_EXEC))
		else $error("result without execute");

	// program write-back and erase never coincide with a running sweep
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !(mem_req.wr_en || mem_req.clear_start))
		else $error("array write during clear");

endmodule

`default_nettype wire

[tb/nfci_checker.sv]
`timescale 1ns / 100ps
// Result checker of the NOR flash command interface: watches the access, result
// and configuration channels, keeps its own flash state and compares each result.
// Depends on nfci_pkg for the command codes, query addresses and read mode type.

module nfci_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [31:0] s_tdata,   // [15:0] address, [31:16] write_data
	input  wire  [0:0]  s_tuser,   // [0] mode
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [15:0] m_tdata,   // [15:0] read_data
	input  wire  [1:0]  m_tuser,   // [1:0] read_mode
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	input  wire  [31:0] prdata,
	input  wire         pready,
	output int          error_count,
	output int          pending
);
	import nfci_pkg::*;

	localparam int PRINT_CAP = 200;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_UNLOCK1,
		SEQ_UNLOCK2,
		SEQ_PROGRAM,
		SEQ_ERASE1,
		SEQ_ERASE2,
		SEQ_ERASE3
	} cmd_seq_t;

	typedef struct packed {
		word_t  data;
		rmode_t mode;
	} access_result_t;

	// shadow of the flash state and registers
	word_t          flash_mem [0:(1<<ADDR_WIDTH)-1];
	cmd_seq_t       cmd_seq;
	rmode_t         rd_mode;
	logic [7:0]     mfr_code;
	word_t          dev_code;
	logic [4:0]     size_code;
	access_result_t response_q [$];

	initial begin
		error_count = 0;
		pending = 0;
	end

	task automatic report(input string msg);
		if (error_count < PRINT_CAP)
			$display("%0t nfci_checker: %s", $time, msg);
		error_count++;
	endtask

	task automatic erase_all();
		for (int i = 0; i < (1 << ADDR_WIDTH); i++)
			flash_mem[i] = ERASED_WORD;
	endtask

	// word seen by a read in the current read mode
	function automatic word_t flash_read(input logic [15:0] a);
		case (rd_mode)
			RM_ID: begin
				case (a)
					ID_ADDR_MFR: return {8'd0, mfr_code};
					ID_ADDR_DEV: return dev_code;
					default: return '0;
				endcase
			end
			RM_CFI: begin
				case (a)
					CFI_ADDR_Q:    return CFI_Q;
					CFI_ADDR_R:    return CFI_R;
					CFI_ADDR_Y:    return CFI_Y;
					CFI_ADDR_CS0:  return CFI_CS0;
					CFI_ADDR_CS1:  return CFI_CS1;
					CFI_ADDR_SIZE: return word_t'(size_code);
					default: return '0;
				endcase
			end
			default: return flash_mem[aidx_t'(a)];
		endcase
	endfunction

	// command sequencer: any write that does not fit drops back to idle
	task automatic flash_write(input logic [15:0] a, input word_t d);
		logic [7:0] c;
		cmd_seq_t   next_seq;
		c = d[7:0];
		next_seq = SEQ_IDLE;
		case (cmd_seq)
			SEQ_IDLE: if (a == UNLOCK_A && c == CMD_UNLOCK1) next_seq = SEQ_UNLOCK1;
			SEQ_UNLOCK1: if (a == UNLOCK_B && c == CMD_UNLOCK2) next_seq = SEQ_UNLOCK2;
			SEQ_UNLOCK2: begin
				if (a == UNLOCK_A) begin
					case (c)
						CMD_ID_ENTRY:  rd_mode = RM_ID;
						CMD_CFI_ENTRY: rd_mode = RM_CFI;
						CMD_RESET:     rd_mode = RM_ARRAY;
						CMD_PROGRAM:   next_seq = SEQ_PROGRAM;
						CMD_ERASE:     next_seq = SEQ_ERASE1;
						default: ;
					endcase
				end
			end
			SEQ_PROGRAM: flash_mem[aidx_t'(a)] &= d;
			SEQ_ERASE1: if (a == UNLOCK_A && c == CMD_UNLOCK1) next_seq = SEQ_ERASE2;
			SEQ_ERASE2: if (a == UNLOCK_B && c == CMD_UNLOCK2) next_seq = SEQ_ERASE3;
			SEQ_ERASE3: if (a == UNLOCK_A && c == CMD_ERASE_CHIP) erase_all();
			default: ;
		endcase
		cmd_seq = next_seq;
	endtask

	function automatic logic [31:0] reg_value(input logic [3:0] a);
		case (a[3:2])
			REG_MFR_CODE:  return {24'd0, mfr_code};
			REG_DEV_CODE:  return {16'd0, dev_code};
			REG_SIZE_CODE: return {27'd0, size_code};
			default: return 32'd0;
		endcase
	endfunction

	// monitor all three channels on each edge
	always @(posedge clk or negedge arst_n) begin
		access_result_t exp_word;
		word_t          rd;
		if (!arst_n) begin
			erase_all();
			cmd_seq = SEQ_IDLE;
			rd_mode = RM_ARRAY;
			mfr_code = MFR_CODE_RST;
			dev_code = DEV_CODE_RST;
			size_code = SIZE_CODE_RST;
			response_q.delete();
			pending = 0;
		end else begin
			// configuration port
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_MFR_CODE:  mfr_code = pwdata[7:0];
						REG_DEV_CODE:  dev_code = pwdata[15:0];
						REG_SIZE_CODE: size_code = pwdata[4:0];
						default: ;
					endcase
				end else if (prdata !== reg_value(paddr)) begin
					report($sformatf("register read at %h: got %h, want %h",
						paddr, prdata, reg_value(paddr)));
				end
			end
			// access word accepted
			if (s_tvalid && s_tready) begin
				rd = '0;
				if (s_tuser[0])
					flash_write(s_tdata[15:0], s_tdata[31:16]);
				else
					rd = flash_read(s_tdata[15:0]);
				response_q.push_back('{rd, rd_mode});
			end
			// result word accepted
			if (m_tvalid && m_tready) begin
				if (response_q.size() == 0) begin
					report($sformatf("result word with none expected: data %h mode %0d",
						m_tdata, m_tuser));
				end else begin
					exp_word = response_q.pop_front();
					if (m_tdata !== exp_word.data)
						report($sformatf("read_data %h, want %h", m_tdata, exp_word.data));
					if (m_tuser !== exp_word.mode)
						report($sformatf("read_mode %0d, want %0d", m_tuser, exp_word.mode));
				end
			end
			pending = response_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the NOR flash command interface testbench: clock, reset, access and
// configuration stimulus, receiver stalls and the verdict; needs nfci_checker.

module tb_top;
	import nfci_pkg::*;

	localparam int STALL_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_WORDS  = 290;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] address, [31:16] write_data
	logic [0:0]  s_tuser;   // [0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] read_data
	logic [1:0]  m_tuser;   // [1:0] read_mode
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int chk_errors;
	int chk_pending;

	int sent;
	int burst_left;
	int erases_left;
	bit mix_reads;
	bit hold_req;
	int hold_left;
	int rx_style;
	int rx_style_left;
	int idle_cycles;
	logic [15:0] hot_addr [8];

	nor_flash_command_interface_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	nfci_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.error_count(chk_errors),
		.pending    (chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: long hold-off on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_style_left == 0) begin
				rx_style = $urandom_range(0, 3);
				rx_style_left = $urandom_range(16, 128);
			end
			rx_style_left--;
			case (rx_style)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ~m_tready;
			endcase
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// one access word; bursts of random length with random gaps in between
	task automatic bus_access(input logic wr, input logic [15:0] a, input word_t d);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {d, a};
		s_tuser <= wr;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sent++;
	endtask

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom_range(0, 16'h30));
			2: return ($urandom_range(0, 1) != 0) ? UNLOCK_A : UNLOCK_B;
			3, 4: return hot_addr[$urandom_range(0, 7)];
			default: return 16'($urandom);
		endcase
	endfunction

	// command write, high byte random; in random traffic a read may slip in first
	task automatic cmd_write(input logic [15:0] a, input logic [7:0] c);
		if (mix_reads && $urandom_range(0, 7) == 0)
			bus_access(1'b0, pick_addr(), 16'($urandom));
		bus_access(1'b1, a, {8'($urandom), c});
	endtask

	task automatic unlock();
		cmd_write(UNLOCK_A, CMD_UNLOCK1);
		cmd_write(UNLOCK_B, CMD_UNLOCK2);
	endtask

	task automatic command(input logic [7:0] c);
		unlock();
		cmd_write(UNLOCK_A, c);
	endtask

	task automatic program_word(input logic [15:0] a, input word_t d);
		command(CMD_PROGRAM);
		bus_access(1'b1, a, d);
	endtask

	task automatic chip_erase();
		command(CMD_ERASE);
		unlock();
		cmd_write(UNLOCK_A, CMD_ERASE_CHIP);
	endtask

	function automatic logic [7:0] pick_mode_cmd();
		case ($urandom_range(0, 3))
			0: return CMD_ID_ENTRY;
			1: return CMD_CFI_ENTRY;
			default: return CMD_RESET;
		endcase
	endfunction

	// one random sequence, mostly well formed
	task automatic random_sequence();
		int         kind;
		logic [7:0] c;
		logic [15:0] a;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			repeat ($urandom_range(1, 3)) bus_access(1'b0, pick_addr(), 16'($urandom));
		end else if (kind < 55) begin
			a = pick_addr();
			program_word(a, 16'($urandom));
			if ($urandom_range(0, 1) != 0)
				bus_access(1'b0, a, 16'($urandom));
		end else if (kind < 65) begin
			command(pick_mode_cmd());
		end else if (kind < 70) begin
			// unknown command after the unlock pair
			do c = 8'($urandom); while (c == CMD_ID_ENTRY || c == CMD_CFI_ENTRY ||
				c == CMD_RESET || c == CMD_PROGRAM || c == CMD_ERASE);
			command(c);
		end else if (kind < 80) begin
			// broken sequences
			case ($urandom_range(0, 3))
				0: begin
					cmd_write(UNLOCK_A, CMD_UNLOCK1);
					bus_access(1'b1, pick_addr(), 16'($urandom));
				end
				1: begin
					// a repeated first unlock does not restart the sequence
					cmd_write(UNLOCK_A, CMD_UNLOCK1);
					cmd_write(UNLOCK_A, CMD_UNLOCK1);
					cmd_write(UNLOCK_B, CMD_UNLOCK2);
					cmd_write(UNLOCK_A, pick_mode_cmd());
				end
				2: begin
					unlock();
					cmd_write(($urandom_range(0, 1) != 0) ? UNLOCK_B : pick_addr(),
						pick_mode_cmd());
				end
				default: begin
					command(CMD_ERASE);
					if ($urandom_range(0, 1) != 0) begin
						cmd_write(UNLOCK_A, CMD_UNLOCK1);
						if ($urandom_range(0, 1) != 0)
							cmd_write(UNLOCK_B, CMD_UNLOCK2);
					end
					bus_access(1'b1, pick_addr(), 16'($urandom));
				end
			endcase
		end else if (kind < 82 && erases_left > 0) begin
			erases_left--;
			chip_erase();
		end else begin
			bus_access(1'b1, pick_addr(), 16'($urandom));
		end
	endtask

	// wait until every expected result word has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
	endtask

	// one APB transfer; psel stays high so transfers can run back to back
	task automatic apb_xfer(input logic wr, input logic [3:0] a, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// write all registers with junk above their width, then read them back
	task automatic configure(input logic [7:0] mfr, input word_t dev, input logic [4:0] sz,
		input bit poke_unused);
		logic [31:0] d;
		d = $urandom;
		d[7:0] = mfr;
		apb_xfer(1'b1, {REG_MFR_CODE, 2'b00}, d);
		d = $urandom;
		d[15:0] = dev;
		apb_xfer(1'b1, {REG_DEV_CODE, 2'b00}, d);
		d = $urandom;
		d[4:0] = sz;
		apb_xfer(1'b1, {REG_SIZE_CODE, 2'b00}, d);
		if (poke_unused)
			apb_xfer(1'b1, 4'hC, $urandom);
		apb_xfer(1'b0, {REG_MFR_CODE, 2'b00}, 32'd0);
		apb_xfer(1'b0, {REG_DEV_CODE, 2'b00}, 32'd0);
		apb_xfer(1'b0, {REG_SIZE_CODE, 2'b00}, 32'd0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent = 0;
		burst_left = 0;
		erases_left = 3;
		mix_reads = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		rx_style = 0;
		rx_style_left = 0;
		idle_cycles = 0;
		hot_addr[0] = 16'h0000;
		hot_addr[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			hot_addr[i] = 16'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset register values, array extremes, every command
		bus_access(1'b0, 16'h0000, 16'hFFFF);
		bus_access(1'b0, 16'hFFFF, 16'h0000);
		unlock();
		bus_access(1'b0, UNLOCK_A, 16'h0000);      // read inside a sequence
		cmd_write(UNLOCK_A, CMD_PROGRAM);
		bus_access(1'b1, 16'hFFFF, 16'h00FF);
		bus_access(1'b0, 16'hFFFF, 16'hFFFF);
		command(CMD_ID_ENTRY);
		bus_access(1'b0, ID_ADDR_MFR, 16'h0000);
		bus_access(1'b0, ID_ADDR_DEV, 16'h0000);
		command(CMD_CFI_ENTRY);
		bus_access(1'b0, CFI_ADDR_Q, 16'h0000);
		bus_access(1'b0, CFI_ADDR_SIZE, 16'h0000);
		chip_erase();                              // erase while in query mode
		command(CMD_RESET);
		bus_access(1'b0, 16'hFFFF, 16'h0000);

		// random phases, each under its own register setting
		mix_reads = 1'b1;
		for (int p = 1; p <= 4; p++) begin
			drain_results();
			case (p)
				1: configure(8'h00, 16'h0000, 5'd9, 1'b0);
				2: configure(8'hFF, 16'hFFFF, 5'd31, 1'b1);
				default: configure(8'($urandom), 16'($urandom), 5'($urandom_range(9, 31)), 1'b0);
			endcase
			if (p == 2) begin
				// receiver holds off while reads keep coming
				hold_req = 1'b1;
				burst_left = 64;
				repeat (64) bus_access(1'b0, pick_addr(), 16'($urandom));
			end
			target = sent + PHASE_WORDS;
			while (sent < target)
				random_sequence();
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (chk_errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

[files.f]
design/nfci_pkg.sv
design/nfci_cmd.sv
design/nfci_array.sv
design/nor_flash_command_interface_unit.sv
tb/nfci_checker.sv
tb/tb_top.sv
